### hdl/scbc_pkg.sv
package scbc_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_CLS,
        ST_LSCAN,
        ST_LSHIFT,
        ST_FSHIFT,
        ST_DONE
    } state_t;

    localparam logic [1:0] ROUTE_BACKING = 2'd0;
    localparam logic [1:0] ROUTE_BUCKET  = 2'd1;
    localparam logic [1:0] ROUTE_LIST    = 2'd2;

    localparam logic [2:0] REG_THR_LOW   = 3'd0;
    localparam logic [2:0] REG_THR_HIGH  = 3'd1;
    localparam logic [2:0] REG_FIRST     = 3'd2;
    localparam logic [2:0] REG_STEP      = 3'd3;
    localparam logic [2:0] REG_CLASSES   = 3'd4;
    localparam logic [2:0] REG_LIST_MASK = 3'd5;
    localparam logic [2:0] REG_BACK_MASK = 3'd6;

    // one restoring-division step: remainder and quotient shifted by one bit
    typedef struct packed {
        logic [32:0] rem;
        logic [31:0] quo;
    } div_step_t;

    function automatic logic [31:0] align_sat(input logic [31:0] s, input logic [11:0] m);
        logic [32:0] v;
        logic [31:0] neg;
        neg = 32'd0 - s;
        v = {1'b0, s} + {21'd0, neg[11:0] & m};
        align_sat = v[32] ? 32'hFFFF_FFFF : v[31:0];
    endfunction

endpackage

### hdl/scbc_div.sv
module scbc_div
    import scbc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [31:0] quotient
);
    // bit-serial restoring divider, one quotient bit per cycle
    logic [32:0] rem_reg, rem_next;
    logic [31:0] quo_reg, quo_next;
    logic [31:0] dvs_reg, dvs_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    div_step_t   st;

    always_comb
    begin
        st.rem = {rem_reg[31:0], quo_reg[31]};
        st.quo = {quo_reg[30:0], 1'b0};
        if (st.rem >= {1'b0, dvs_reg})
        begin
            st.rem = st.rem - {1'b0, dvs_reg};
            st.quo[0] = 1'b1;
        end
        rem_next = rem_reg;
        quo_next = quo_reg;
        dvs_next = dvs_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done = 1'b0;
        if (start)
        begin
            rem_next = 33'd0;
            quo_next = dividend;
            dvs_next = divisor;
            cnt_next = 6'd0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = st.rem;
            quo_next = st.quo;
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd31)
                busy_next = 1'b0;
        end
        else
        begin
            done = 1'b1;
        end
    end

    assign quotient = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 6'd0;
            busy_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end
endmodule

### hdl/size_class_block_cache_top.sv
// Routes: the backing route goes from the multiply state to the result; the bucket route adds the 32-step divider
//   plus setup, class multiply and stack update; the list route adds the serial first-fit walk
//   or the one-entry-a-cycle shift.
// Throughput: one word at a time; s_tready is low until the result is taken.
// Reset (rst_n, async low): registers to defaults, all fills zero, no pending word.
module size_class_block_cache_top
    import scbc_pkg::*;
#(
    parameter int MAX_CLASSES  = 16,
    parameter int STACK_DEPTH  = 16,
    parameter int LIST_DEPTH   = 16,
    parameter int HANDLE_WIDTH = 32
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic         s_tuser,   // req_type
    input  logic [63:0]  s_tdata,   // req_size[31:0], free_handle[63:32]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata    // route[1:0], class_index[5:2], granted_size[37:6],
                                    // hit[38], hit_handle[70:39], release_valid[71],
                                    // release_handle[103:72]
);
    localparam int CW = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
    localparam int SW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int FW = $clog2(STACK_DEPTH + 1);
    localparam int LD = (LIST_DEPTH > 0) ? LIST_DEPTH : 1;
    localparam int LW = (LD > 1) ? $clog2(LD) : 1;
    localparam int LFW = $clog2(LD + 1);
    localparam int NW = $clog2(MAX_CLASSES + 1);
    localparam int HW = HANDLE_WIDTH;
    localparam int AW = (MAX_CLASSES * STACK_DEPTH > 1) ? $clog2(MAX_CLASSES * STACK_DEPTH) : 1;

    logic [31:0] thr_low_reg, thr_high_reg, first_reg, step_reg;
    logic [4:0]  classes_reg;
    logic [11:0] lmask_reg, bmask_reg;

    logic [HW-1:0]  stack_mem [MAX_CLASSES*STACK_DEPTH];
    logic [FW-1:0]  fill_reg [MAX_CLASSES];
    logic [HW-1:0]  lh_reg [LD];
    logic [31:0]    ls_reg [LD];
    logic [LFW-1:0] lfill_reg;

    state_t state_reg, state_next;
    logic        is_free_reg;
    logic [31:0] size_reg;
    logic [HW-1:0] h_reg;
    logic [1:0]  route_reg;
    logic [3:0]  cls_reg;
    logic [31:0] gsz_reg;
    logic        hit_reg, rel_reg;
    logic [HW-1:0] hh_reg, rh_reg;
    logic [LW:0] ptr_reg;
    logic [CW-1:0] k_reg;
    logic [63:0] prod_reg;
    logic        busy_reg;

    logic [NW-1:0] n_val;
    assign n_val = ({27'd0, classes_reg} > 32'(MAX_CLASSES)) ? NW'(MAX_CLASSES)
                                                             : NW'(classes_reg);

    function automatic logic is_mid_list(input logic [64:0] l);
        is_mid_list = (n_val == NW'(0)) || ({33'd0, size_reg} > l);
    endfunction

    // shared multiplier: step * operand
    logic [31:0] mul_op;
    logic [63:0] mul_res;
    assign mul_op = (state_reg == ST_IDLE) ? 32'(n_val - NW'(1)) : {{(32-CW){1'b0}}, k_reg};
    assign mul_res = step_reg * mul_op;

    logic div_start, div_done;
    logic [31:0] quo;
    scbc_div u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start),
        .dividend(size_reg - first_reg - 32'd1), .divisor(step_reg),
        .done(div_done), .quotient(quo)
    );

    // first + step * operand, exact
    logic [64:0] lim;
    assign lim = {33'd0, first_reg} + {1'b0, prod_reg};

    logic [SW-1:0] top_idx;
    assign top_idx = SW'(fill_reg[k_reg] - FW'(1));
    logic [SW-1:0] push_idx;
    assign push_idx = SW'(fill_reg[k_reg]);
    logic [AW-1:0] pop_addr, push_addr;
    assign pop_addr = AW'(32'(k_reg) * 32'(STACK_DEPTH) + 32'(top_idx));
    assign push_addr = AW'(32'(k_reg) * 32'(STACK_DEPTH) + 32'(push_idx));

    logic accept;
    assign s_tready = (state_reg == ST_IDLE) && !busy_reg;
    assign accept = s_tvalid && s_tready;
    assign m_tvalid = busy_reg && (state_reg == ST_DONE);
    assign div_start = (state_reg == ST_MUL) && !((is_mid_list(lim)));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (accept) state_next = ST_MUL;
            ST_MUL:
            begin
                if (route_reg == ROUTE_BACKING) state_next = ST_DONE;
                else if (is_mid_list(lim)) state_next = is_free_reg ? ST_FSHIFT : ST_LSCAN;
                else state_next = ST_DIV;
            end
            ST_DIV:    if (div_done) state_next = ST_CLS;
            ST_CLS:    state_next = ST_LSHIFT;
            ST_LSCAN:  if (hit_reg || ptr_reg >= (LW+1)'(lfill_reg)) state_next = ST_LSHIFT;
            ST_LSHIFT: if (route_reg != ROUTE_LIST || !hit_reg
                           || ptr_reg + (LW+1)'(1) >= (LW+1)'(lfill_reg)) state_next = ST_DONE;
            ST_FSHIFT: if (ptr_reg == '0) state_next = ST_DONE;
            ST_DONE:   if (m_tready) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            busy_reg <= 1'b0;
            thr_low_reg <= 32'd0;
            thr_high_reg <= 32'd65536;
            first_reg <= 32'd16;
            step_reg <= 32'd16;
            classes_reg <= 5'd16;
            lmask_reg <= 12'd7;
            bmask_reg <= 12'd7;
            lfill_reg <= '0;
            for (int i = 0; i < MAX_CLASSES; i++)
                fill_reg[i] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept) busy_reg <= 1'b1;
            else if (m_tvalid && m_tready) busy_reg <= 1'b0;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_THR_LOW:   thr_low_reg <= cfg_data;
                    REG_THR_HIGH:  thr_high_reg <= cfg_data;
                    REG_FIRST:     first_reg <= cfg_data;
                    REG_STEP:      step_reg <= cfg_data;
                    REG_CLASSES:   classes_reg <= cfg_data[4:0];
                    REG_LIST_MASK: lmask_reg <= cfg_data[11:0];
                    REG_BACK_MASK: bmask_reg <= cfg_data[11:0];
                    default: ;
                endcase
            end
            if (state_reg == ST_LSHIFT && route_reg == ROUTE_BUCKET)
            begin
                if (!is_free_reg && fill_reg[k_reg] != '0)
                    fill_reg[k_reg] <= fill_reg[k_reg] - FW'(1);
                else if (is_free_reg && 32'(fill_reg[k_reg]) < 32'(STACK_DEPTH))
                    fill_reg[k_reg] <= fill_reg[k_reg] + FW'(1);
            end
            if (state_reg == ST_LSHIFT && route_reg == ROUTE_LIST && hit_reg
                && state_next == ST_DONE)
                lfill_reg <= lfill_reg - LFW'(1);
            if (state_reg == ST_FSHIFT && ptr_reg == '0 && LIST_DEPTH > 0
                && 32'(lfill_reg) < 32'(LIST_DEPTH))
                lfill_reg <= lfill_reg + LFW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    is_free_reg <= s_tuser;
                    size_reg <= s_tdata[31:0];
                    h_reg <= HW'(s_tdata[63:32]);
                    prod_reg <= mul_res;
                    cls_reg <= 4'd0;
                    hit_reg <= 1'b0;
                    hh_reg <= '0;
                    rel_reg <= 1'b0;
                    rh_reg <= '0;
                    ptr_reg <= '0;
                    if (s_tdata[31:0] <= thr_low_reg || s_tdata[31:0] >= thr_high_reg)
                    begin
                        route_reg <= ROUTE_BACKING;
                        gsz_reg <= align_sat(s_tdata[31:0], bmask_reg);
                        if (s_tuser)
                        begin
                            rel_reg <= 1'b1;
                            rh_reg <= HW'(s_tdata[63:32]);
                        end
                    end
                    else
                        route_reg <= ROUTE_BUCKET;
                end
            end
            ST_MUL:
            begin
                if (route_reg != ROUTE_BACKING && is_mid_list(lim))
                begin
                    route_reg <= ROUTE_LIST;
                    gsz_reg <= align_sat(size_reg, lmask_reg);
                    if (is_free_reg)
                    begin
                        if (LIST_DEPTH == 0)
                        begin
                            rel_reg <= 1'b1;
                            rh_reg <= h_reg;
                            ptr_reg <= '0;
                        end
                        else if (32'(lfill_reg) >= 32'(LIST_DEPTH))
                        begin
                            rel_reg <= 1'b1;
                            rh_reg <= lh_reg[LW'(LD-1)];
                            ptr_reg <= (LW+1)'(LD-1);
                        end
                        else
                            ptr_reg <= (LW+1)'(lfill_reg);
                    end
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    if (size_reg <= first_reg || step_reg == 32'd0)
                        k_reg <= '0;
                    else if ({1'b0, quo} + 33'd1 >= 33'(n_val))
                        k_reg <= CW'(n_val - NW'(1));
                    else
                        k_reg <= CW'(quo + 32'd1);
                end
            end
            ST_CLS:
            begin
                cls_reg <= 4'(k_reg);
                prod_reg <= mul_res;
            end
            ST_LSCAN:
            begin
                if (!hit_reg && ptr_reg < (LW+1)'(lfill_reg))
                begin
                    if (ls_reg[ptr_reg[LW-1:0]] >= gsz_reg)
                    begin
                        hit_reg <= 1'b1;
                        gsz_reg <= ls_reg[ptr_reg[LW-1:0]];
                        hh_reg <= lh_reg[ptr_reg[LW-1:0]];
                    end
                    else
                        ptr_reg <= ptr_reg + (LW+1)'(1);
                end
            end
            ST_LSHIFT:
            begin
                if (route_reg == ROUTE_BUCKET)
                begin
                    gsz_reg <= (lim > 65'h0_FFFF_FFFF) ? 32'hFFFF_FFFF : lim[31:0];
                    if (!is_free_reg && fill_reg[k_reg] != '0)
                    begin
                        hit_reg <= 1'b1;
                        hh_reg <= stack_mem[pop_addr];
                    end
                    else if (is_free_reg && 32'(fill_reg[k_reg]) < 32'(STACK_DEPTH))
                        stack_mem[push_addr] <= h_reg;
                    else if (is_free_reg)
                    begin
                        rel_reg <= 1'b1;
                        rh_reg <= h_reg;
                    end
                end
                else if (hit_reg && ptr_reg + (LW+1)'(1) < (LW+1)'(lfill_reg))
                begin
                    lh_reg[ptr_reg[LW-1:0]] <= lh_reg[LW'(ptr_reg + (LW+1)'(1))];
                    ls_reg[ptr_reg[LW-1:0]] <= ls_reg[LW'(ptr_reg + (LW+1)'(1))];
                    ptr_reg <= ptr_reg + (LW+1)'(1);
                end
            end
            ST_FSHIFT:
            begin
                if (LIST_DEPTH > 0)
                begin
                    if (ptr_reg == '0)
                    begin
                        lh_reg[0] <= h_reg;
                        ls_reg[0] <= size_reg;
                    end
                    else
                    begin
                        lh_reg[ptr_reg[LW-1:0]] <= lh_reg[LW'(ptr_reg - (LW+1)'(1))];
                        ls_reg[ptr_reg[LW-1:0]] <= ls_reg[LW'(ptr_reg - (LW+1)'(1))];
                        ptr_reg <= ptr_reg - (LW+1)'(1);
                    end
                end
            end
            default: ;
        endcase
    end

    assign m_tdata = {32'(rh_reg), rel_reg, 32'(hh_reg), hit_reg, gsz_reg,
                      cls_reg, route_reg};

    property p_no_ready_busy;
        @(posedge clk) disable iff (!rst_n) m_tvalid |-> !s_tready;
    endproperty
    assert property (p_no_ready_busy) else $error("ready while result pending");

    property p_lfill_bound;
        @(posedge clk) disable iff (!rst_n) 32'(lfill_reg) <= 32'(LIST_DEPTH);
    endproperty
    assert property (p_lfill_bound) else $error("list fill overflow");

    property p_hit_alloc;
        @(posedge clk) disable iff (!rst_n) (m_tvalid && hit_reg) |-> !is_free_reg;
    endproperty
    assert property (p_hit_alloc) else $error("hit on free");
endmodule

### tb/sv/size_class_block_cache_checker.sv
`timescale 1ns / 100ps
module size_class_block_cache_checker
    import scbc_pkg::*;
#(
    parameter int MAX_CLASSES  = 16,
    parameter int STACK_DEPTH  = 16,
    parameter int LIST_DEPTH   = 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic         s_tuser,
    input  logic [63:0]  s_tdata,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [103:0] m_tdata,
    output int           errors,
    output int           pending
);
    logic [31:0] thr_low, thr_high, first_size, step;
    logic [4:0]  n_classes;
    logic [11:0] list_mask, back_mask;

    logic [31:0] bucket_stack [MAX_CLASSES][STACK_DEPTH];
    int          bucket_fill [MAX_CLASSES];
    logic [31:0] free_handles [$];   // index 0 newest
    logic [31:0] free_sizes [$];

    logic [103:0] expected_words [$];

    assign pending = expected_words.size();

    function automatic logic [31:0] round_up(logic [31:0] s, logic [11:0] m);
        logic [32:0] v;
        logic [31:0] neg;
        neg = 32'd0 - s;
        v = {1'b0, s} + {21'd0, neg[11:0] & m};
        return v[32] ? 32'hFFFF_FFFF : v[31:0];
    endfunction

    function automatic logic [31:0] sat_size(logic [63:0] v);
        return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
    endfunction

    task automatic predict_request(input logic is_free, input logic [31:0] s,
                                   input logic [31:0] h);
        logic [1:0]  route;
        logic [3:0]  cls;
        logic [31:0] granted, hit_h, rel_h;
        logic        hit, rel;
        logic [63:0] idx, top_size;
        int          n, k;
        route = ROUTE_BACKING; cls = '0; granted = '0; hit = 1'b0; hit_h = '0;
        rel = 1'b0; rel_h = '0;
        n = (n_classes > MAX_CLASSES) ? MAX_CLASSES : n_classes;
        top_size = {32'd0, first_size} + {32'd0, step} * (n - 1);
        if (s <= thr_low || s >= thr_high) begin
            granted = round_up(s, back_mask);
            if (is_free) begin
                rel = 1'b1; rel_h = h;
            end
        end else if (n == 0 || {32'd0, s} > top_size) begin
            route = ROUTE_LIST;
            granted = round_up(s, list_mask);
            if (!is_free) begin
                for (int i = 0; i < free_sizes.size(); i++) begin
                    if (free_sizes[i] >= granted) begin
                        granted = free_sizes[i];
                        hit = 1'b1;
                        hit_h = free_handles[i];
                        free_sizes.delete(i);
                        free_handles.delete(i);
                        break;
                    end
                end
            end else if (LIST_DEPTH == 0) begin
                rel = 1'b1; rel_h = h;
            end else begin
                if (free_sizes.size() >= LIST_DEPTH) begin
                    rel = 1'b1;
                    rel_h = free_handles.pop_back();
                    void'(free_sizes.pop_back());
                end
                free_handles.insert(0, h);
                free_sizes.insert(0, s);
            end
        end else begin
            idx = '0;
            if (s > first_size && step != 0)
                idx = ({32'd0, s} - first_size - 1) / step + 1;
            if (idx >= n) idx = n - 1;
            k = int'(idx);
            route = ROUTE_BUCKET;
            cls = idx[3:0];
            granted = sat_size({32'd0, first_size} + {32'd0, step} * idx);
            if (!is_free) begin
                if (bucket_fill[k] > 0) begin
                    bucket_fill[k]--;
                    hit = 1'b1;
                    hit_h = bucket_stack[k][bucket_fill[k]];
                end
            end else if (bucket_fill[k] < STACK_DEPTH) begin
                bucket_stack[k][bucket_fill[k]] = h;
                bucket_fill[k]++;
            end else begin
                rel = 1'b1; rel_h = h;
            end
        end
        expected_words.push_back({rel_h, rel, hit_h, hit, granted, cls, route});
    endtask

    always @(posedge clk or negedge rst_n) begin
        logic [103:0] want, got;
        if (!rst_n) begin
            thr_low <= 32'd0; thr_high <= 32'd65536; first_size <= 32'd16; step <= 32'd16;
            n_classes <= 5'd16; list_mask <= 12'd7; back_mask <= 12'd7;
            for (int i = 0; i < MAX_CLASSES; i++) bucket_fill[i] = 0;
            free_handles.delete();
            free_sizes.delete();
            expected_words.delete();
            errors <= 0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_THR_LOW:   thr_low <= cfg_data;
                    REG_THR_HIGH:  thr_high <= cfg_data;
                    REG_FIRST:     first_size <= cfg_data;
                    REG_STEP:      step <= cfg_data;
                    REG_CLASSES:   n_classes <= cfg_data[4:0];
                    REG_LIST_MASK: list_mask <= cfg_data[11:0];
                    REG_BACK_MASK: back_mask <= cfg_data[11:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                predict_request(s_tuser, s_tdata[31:0], s_tdata[63:32]);
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (expected_words.size() == 0) begin
                    $display("%0t: unexpected result word %h", $time, got);
                    errors <= errors + 1;
                end else begin
                    want = expected_words.pop_front();
                    if (got[1:0] !== want[1:0] || got[5:2] !== want[5:2]
                        || got[37:6] !== want[37:6] || got[38] !== want[38]
                        || got[70:39] !== want[70:39] || got[71] !== want[71]
                        || got[103:72] !== want[103:72]) begin
                        $display("%0t: mismatch expected %h actual %h", $time, want,
                                 got);
                        errors <= errors + 1;
                    end
                end
            end
        end
    end
endmodule

### tb/sv/size_class_block_cache_top_tb.sv
`timescale 1ns / 100ps
module size_class_block_cache_top_tb;
    import scbc_pkg::*;

    logic         clk;
    logic         rst_n;
    logic         cfg_we;
    logic [2:0]   cfg_index;
    logic [31:0]  cfg_data;
    logic         s_tvalid;
    logic         s_tready;
    logic         s_tuser;
    logic [63:0]  s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [103:0] m_tdata;
    int           errors;
    int           pending;
    int           long_stall;

    size_class_block_cache_top i_dut (.*);

    size_class_block_cache_checker i_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #4000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // receiver: random stalls, one long hold-off on request
    initial
    begin
        int gap;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (long_stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (long_stall) @(posedge clk);
                long_stall = 0;
            end
            gap = $urandom_range(0, 4);
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid) @(posedge clk);
        end
    end

    task automatic send_word(input logic kind, input logic [31:0] s, input logic [31:0] h,
                             input int gap);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= {h, s};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending > 0) @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // sizes biased to land in all three routes of the current setting
    function automatic logic [31:0] pick_size();
        case ($urandom_range(0, 9))
            0: return $urandom();
            1: return $urandom_range(0, 8);
            2, 3: return $urandom_range(1, 300);
            4: return $urandom_range(60000, 70000);
            default: return $urandom_range(1, 2000);
        endcase
    endfunction

    task automatic random_phase(input int count);
        logic [31:0] sizes [$];
        logic [31:0] s;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 1) && sizes.size() > 0)
            begin
                s = sizes[$urandom_range(0, sizes.size() - 1)];
                send_word(1'b1, s, $urandom(), $urandom_range(0, 4));
            end
            else
            begin
                s = pick_size();
                if ($urandom_range(0, 1)) sizes.push_back(s);
                send_word(1'($urandom_range(0, 1)), s, $urandom(), $urandom_range(0, 4));
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_THR_LOW;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tuser = 1'b0;
        s_tdata = '0;
        long_stall = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: field extremes, bucket overflow, list eviction
        send_word(1'b0, 32'd0, 32'd0, 0);
        send_word(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
        send_word(1'b1, 32'hFFFF_FFF9, 32'h1234_5678, 0);
        send_word(1'b0, 32'd16, 32'd0, 0);
        send_word(1'b1, 32'd17, 32'hAAAA_5555, 0);
        send_word(1'b0, 32'd20, 32'd0, 0);
        for (int i = 0; i < 17; i++) send_word(1'b1, 32'd5, i, 0);
        send_word(1'b0, 32'd1, 32'd0, 0);
        drain();
        for (int i = 0; i < 18; i++) send_word(1'b1, 300 + i, 32'h8000_0000 | i, 0);
        send_word(1'b0, 32'd300, 32'd0, 0);
        send_word(1'b0, 32'd40000, 32'd0, 0);
        drain();

        // long receiver hold-off while input keeps coming
        long_stall = 200;
        random_phase(20);
        drain();
        random_phase(450);
        drain();

        // zero classes, wide masks, tight thresholds
        write_reg(REG_CLASSES, 32'd0);
        write_reg(REG_LIST_MASK, 32'hFFF);
        write_reg(REG_BACK_MASK, 32'hFFF);
        write_reg(REG_THR_LOW, 32'd8);
        random_phase(300);
        drain();

        // zero step, few classes, maximal high threshold
        write_reg(REG_CLASSES, 32'd3);
        write_reg(REG_STEP, 32'd0);
        write_reg(REG_FIRST, 32'd1);
        write_reg(REG_THR_HIGH, 32'hFFFF_FFFF);
        write_reg(REG_LIST_MASK, 32'd0);
        write_reg(REG_BACK_MASK, 32'd0);
        write_reg(REG_THR_LOW, 32'd0);
        random_phase(300);
        drain();

        // huge sizes and steps, class count above the maximum
        write_reg(REG_CLASSES, 32'd31);
        write_reg(REG_STEP, 32'hFFFF_FFFF);
        write_reg(REG_FIRST, 32'hFFFF_FFFF);
        write_reg(REG_LIST_MASK, 32'd63);
        random_phase(200);
        drain();

        write_reg(REG_CLASSES, 32'd16);
        write_reg(REG_STEP, 32'd100);
        write_reg(REG_FIRST, 32'd64);
        write_reg(REG_THR_HIGH, 32'd5000);
        write_reg(REG_THR_LOW, 32'd3);
        write_reg(REG_BACK_MASK, 32'd15);
        random_phase(650);
        drain();

        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
